[src/shs_pkg.sv]
// Package for the servo homing and slew controller: sizes, codes and types.
`timescale 1ns / 1ps

package shs_pkg;

  // Number of servos and the width of a servo index
  localparam int SERVOS = 4;
  localparam int SIDX_W = (SERVOS > 1) ? $clog2(SERVOS) : 1;

  // Field widths
  localparam int ANG_W   = 12;
  localparam int STEP_W  = 4;
  localparam int LIM_W   = 10;
  localparam int CTR_W   = 8;
  localparam int WDATA_W = 10;

  // Input modes
  localparam logic [1:0] MODE_SET  = 2'd0;
  localparam logic [1:0] MODE_TICK = 2'd1;
  localparam logic [1:0] MODE_HOME = 2'd2;

  // Result kinds
  localparam logic [1:0] KIND_RAMP = 2'd0;
  localparam logic [1:0] KIND_RAW  = 2'd1;
  localparam logic [1:0] KIND_HOME = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_STEP_SIZE    = 2'd0;
  localparam logic [1:0] REG_SEARCH_LIMIT = 2'd1;
  localparam logic [1:0] REG_CENTER_ANGLE = 2'd2;

  // Reset values of the configuration registers
  localparam logic [STEP_W-1:0] STEP_SIZE_RST    = 4'd1;
  localparam logic [LIM_W-1:0]  SEARCH_LIMIT_RST = 10'd400;
  localparam logic [CTR_W-1:0]  CENTER_ANGLE_RST = 8'd90;

  // Raw angle range
  localparam logic signed [ANG_W-1:0] ANG_MAX = 12'sh7FF;
  localparam logic signed [ANG_W-1:0] ANG_MIN = 12'sh800;

  // Per-servo entry kept in the state memory
  typedef struct packed {
    logic signed [ANG_W-1:0] cur;
    logic signed [ANG_W-1:0] tgt;
    logic signed [ANG_W-1:0] raw;
  } entry_t;

  // Homing phase
  typedef enum logic [2:0] {
    PH_IDLE,
    PH_UP,
    PH_BACK,
    PH_DOWN,
    PH_CENTER
  } phase_t;

  // Sequencer state
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_EXEC
  } state_t;

endpackage

[src/shs_state_mem.sv]
// Per-servo state memory: one write and one registered read port, entries read zero until written.
`timescale 1ns / 1ps

module shs_state_mem
  import shs_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              rd_en,
  input  logic [SIDX_W-1:0] rd_addr,
  input  logic              wr_en,
  input  logic [SIDX_W-1:0] wr_addr,
  input  entry_t            wr_data,
  output entry_t            rd_data
);

  entry_t            mem [SERVOS];
  logic [SERVOS-1:0] written;
  entry_t            rd_raw;
  logic              rd_hit;

  // Storage array, written and read in clocked blocks
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_raw <= mem[rd_addr];
    end
  end

  // Written flags stand in for the zero reset of the array
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
      rd_hit  <= 1'b0;
    end else begin
      if (wr_en) begin
        written[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_hit <= written[rd_addr];
      end
    end
  end

  assign rd_data = rd_hit ? rd_raw : '0;

endmodule

[src/servo_homing_and_slew_controller_core.sv]
// Top level: item sequencer, ramp and homing logic around the per-servo state memory.
//
//   channel  direction  handshake              payload
//   in       input      in_valid / in_ready    mode, servo, angle, stop_button
//   out      output     out_valid / out_ready  kind, servo_id, value, low_limit,
//                                              high_limit, last
//   cfg      input      wr_en                  wr_index, wr_data
//
// An item is taken in the idle state; a set target to a servo in range or a homing
// tick goes through accept, memory read and read-modify-write; a ramp tick through
// accept and a read and read-modify-write per servo; a home item, an unused mode
// or an out-of-range set ends at accept. Entries are read and written one at a time.
// A result waits in the output register while the next item is accepted; a step
// that emits stalls only while that register is still full.
// Reset is synchronous and holds in_ready low; memory entries read zero until
// written, no clearing pass.
`timescale 1ns / 1ps

module servo_homing_and_slew_controller_core
  import shs_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  // input items
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [1:0]              mode,
  input  logic [3:0]              servo,
  input  logic signed [ANG_W-1:0] angle,
  input  logic                    stop_button,
  // results
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [1:0]              kind,
  output logic [3:0]              servo_id,
  output logic signed [ANG_W-1:0] value,
  output logic signed [ANG_W-1:0] low_limit,
  output logic signed [ANG_W-1:0] high_limit,
  output logic                    last,
  // configuration
  input  logic                    wr_en,
  input  logic [1:0]              wr_index,
  input  logic [WDATA_W-1:0]      wr_data
);

  // Configuration registers
  logic [STEP_W-1:0] step_size;
  logic [LIM_W-1:0]  search_limit;
  logic [CTR_W-1:0]  center_angle;

  // Latched item
  logic [1:0]              mode_q;
  logic [3:0]              servo_q;
  logic signed [ANG_W-1:0] angle_q;
  logic                    button_q;

  // Sequencer and homing control
  state_t            state, state_next;
  phase_t            phase, phase_next;
  logic [SIDX_W-1:0] idx, idx_next;
  logic [SIDX_W-1:0] hs, hs_next;
  logic [LIM_W-1:0]  step_count, step_count_next;
  logic [LIM_W-1:0]  up_steps, up_steps_next;
  logic [LIM_W-1:0]  down_steps, down_steps_next;

  // Memory ports
  logic              rd_en;
  logic [SIDX_W-1:0] rd_addr;
  logic              mem_we;
  logic [SIDX_W-1:0] wr_addr;
  entry_t            mem_wdata;
  entry_t            ent;

  // Result staging
  logic                    emit;
  logic                    out_free;
  logic [1:0]              res_kind;
  logic [SIDX_W-1:0]       res_id;
  logic signed [ANG_W-1:0] res_value;
  logic signed [ANG_W-1:0] res_low;
  logic signed [ANG_W-1:0] res_high;
  logic                    res_last;

  // Datapath terms
  logic                    in_take;
  logic                    servo_ok;
  logic                    homing;
  logic [LIM_W:0]          half_sum;
  logic [LIM_W-1:0]        half;
  logic signed [ANG_W:0]   c13, t13, s13, ramp_up, ramp_dn;
  logic signed [ANG_W-1:0] ramp_pos;
  logic signed [ANG_W-1:0] raw_inc, raw_dec;
  logic signed [ANG_W-1:0] center_s;
  logic                    last_servo;

  assign in_ready = (state == ST_IDLE) && !rst;
  assign in_take  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign servo_ok = ({1'b0, servo} < 5'(SERVOS));
  assign homing   = (phase != PH_IDLE);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      step_size    <= STEP_SIZE_RST;
      search_limit <= SEARCH_LIMIT_RST;
      center_angle <= CENTER_ANGLE_RST;
    end else if (wr_en) begin
      case (wr_index)
        REG_STEP_SIZE:    step_size    <= wr_data[STEP_W-1:0];
        REG_SEARCH_LIMIT: search_limit <= wr_data[LIM_W-1:0];
        REG_CENTER_ANGLE: center_angle <= wr_data[CTR_W-1:0];
        default:          ;
      endcase
    end
  end

  // Item capture
  always_ff @(posedge clk) begin
    if (in_take) begin
      mode_q   <= mode;
      servo_q  <= servo;
      angle_q  <= angle;
      button_q <= stop_button;
    end
  end

  // Ramp one step toward target, clamped at the target
  assign c13      = {ent.cur[ANG_W-1], ent.cur};
  assign t13      = {ent.tgt[ANG_W-1], ent.tgt};
  assign s13      = {{(ANG_W + 1 - STEP_W){1'b0}}, step_size};
  assign ramp_up  = c13 + s13;
  assign ramp_dn  = c13 - s13;

  always_comb begin
    if (c13 < t13) begin
      ramp_pos = (ramp_up > t13) ? ent.tgt : ramp_up[ANG_W-1:0];
    end else if (c13 > t13) begin
      ramp_pos = (ramp_dn < t13) ? ent.tgt : ramp_dn[ANG_W-1:0];
    end else begin
      ramp_pos = ent.cur;
    end
  end

  // Saturating raw moves and homing midpoint
  assign raw_inc    = (ent.raw == ANG_MAX) ? ANG_MAX : ent.raw + 12'sd1;
  assign raw_dec    = (ent.raw == ANG_MIN) ? ANG_MIN : ent.raw - 12'sd1;
  assign half_sum   = {1'b0, up_steps} + {1'b0, down_steps};
  assign half       = half_sum[LIM_W:1];
  assign center_s   = {{(ANG_W - CTR_W){1'b0}}, center_angle};
  assign last_servo = (hs == SIDX_W'(SERVOS - 1));

  // Sequencer: next state, memory controls and result staging
  always_comb begin
    state_next      = state;
    phase_next      = phase;
    idx_next        = idx;
    hs_next         = hs;
    step_count_next = step_count;
    up_steps_next   = up_steps;
    down_steps_next = down_steps;
    rd_en           = 1'b0;
    rd_addr         = idx;
    mem_we          = 1'b0;
    wr_addr         = idx;
    mem_wdata       = ent;
    emit            = 1'b0;
    res_kind        = KIND_RAMP;
    res_id          = idx;
    res_value       = '0;
    res_low         = '0;
    res_high        = '0;
    res_last        = 1'b1;

    case (state)
      ST_IDLE: begin
        if (in_take) begin
          case (mode)
            MODE_SET: begin
              if (servo_ok) begin
                state_next = ST_ISSUE;
              end
            end
            MODE_TICK: begin
              idx_next   = '0;
              state_next = ST_ISSUE;
            end
            MODE_HOME: begin
              if (!homing) begin
                phase_next      = PH_UP;
                hs_next         = '0;
                step_count_next = '0;
                up_steps_next   = '0;
                down_steps_next = '0;
              end
            end
            default: ;
          endcase
        end
      end

      ST_ISSUE: begin
        rd_en = 1'b1;
        if (mode_q == MODE_SET) begin
          rd_addr = servo_q[SIDX_W-1:0];
        end else if (homing) begin
          rd_addr = hs;
        end else begin
          rd_addr = idx;
        end
        state_next = ST_EXEC;
      end

      ST_EXEC: begin
        if (mode_q == MODE_SET) begin
          // store the target, keep the rest of the entry
          mem_we        = 1'b1;
          wr_addr       = servo_q[SIDX_W-1:0];
          mem_wdata.tgt = angle_q;
          state_next    = ST_IDLE;
        end else if (!homing) begin
          // ramp walk, one servo per pass
          emit      = 1'b1;
          res_kind  = KIND_RAMP;
          res_id    = idx;
          res_value = ramp_pos;
          res_last  = (idx == SIDX_W'(SERVOS - 1));
          if (out_free) begin
            mem_we        = 1'b1;
            wr_addr       = idx;
            mem_wdata.cur = ramp_pos;
            if (res_last) begin
              state_next = ST_IDLE;
            end else begin
              idx_next   = idx + 1'b1;
              state_next = ST_ISSUE;
            end
          end
        end else begin
          // one homing move or decision
          res_id  = hs;
          wr_addr = hs;
          case (phase)
            PH_UP, PH_DOWN: begin
              if (button_q && (step_count < search_limit)) begin
                emit      = 1'b1;
                res_kind  = KIND_RAW;
                res_value = (phase == PH_UP) ? raw_inc : raw_dec;
                if (out_free) begin
                  mem_we          = 1'b1;
                  mem_wdata.raw   = res_value;
                  step_count_next = step_count + 1'b1;
                end
              end else if (button_q) begin
                // search ran out with the button still released: failure
                emit      = 1'b1;
                res_kind  = KIND_HOME;
                res_value = '0;
                if (out_free) begin
                  step_count_next = '0;
                  up_steps_next   = '0;
                  down_steps_next = '0;
                  if (last_servo) begin
                    phase_next = PH_IDLE;
                  end else begin
                    hs_next    = hs + 1'b1;
                    phase_next = PH_UP;
                  end
                end
              end else begin
                if (phase == PH_UP) begin
                  up_steps_next = step_count;
                  phase_next    = PH_BACK;
                end else begin
                  down_steps_next = step_count;
                  phase_next      = PH_CENTER;
                end
                step_count_next = '0;
              end
            end
            PH_BACK: begin
              if (step_count < up_steps) begin
                emit      = 1'b1;
                res_kind  = KIND_RAW;
                res_value = raw_dec;
                if (out_free) begin
                  mem_we          = 1'b1;
                  mem_wdata.raw   = raw_dec;
                  step_count_next = step_count + 1'b1;
                end
              end else begin
                step_count_next = '0;
                phase_next      = PH_DOWN;
              end
            end
            PH_CENTER: begin
              emit = 1'b1;
              if (step_count < half) begin
                res_kind  = KIND_RAW;
                res_value = raw_inc;
                if (out_free) begin
                  mem_we          = 1'b1;
                  mem_wdata.raw   = raw_inc;
                  step_count_next = step_count + 1'b1;
                end
              end else begin
                // homed: center the servo and report its limits
                res_kind  = KIND_HOME;
                res_value = 12'sd1;
                res_low   = center_s - {{(ANG_W - LIM_W){1'b0}}, half};
                res_high  = center_s + {{(ANG_W - LIM_W){1'b0}}, half};
                if (out_free) begin
                  mem_we          = 1'b1;
                  mem_wdata.cur   = center_s;
                  mem_wdata.tgt   = center_s;
                  step_count_next = '0;
                  up_steps_next   = '0;
                  down_steps_next = '0;
                  if (last_servo) begin
                    phase_next = PH_IDLE;
                  end else begin
                    hs_next    = hs + 1'b1;
                    phase_next = PH_UP;
                  end
                end
              end
            end
            default: begin
              phase_next = PH_IDLE;
            end
          endcase
          if (!emit || out_free) begin
            state_next = ST_IDLE;
          end
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      phase      <= PH_IDLE;
      idx        <= '0;
      hs         <= '0;
      step_count <= '0;
      up_steps   <= '0;
      down_steps <= '0;
    end else begin
      state      <= state_next;
      phase      <= phase_next;
      idx        <= idx_next;
      hs         <= hs_next;
      step_count <= step_count_next;
      up_steps   <= up_steps_next;
      down_steps <= down_steps_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit && out_free) begin
      kind       <= res_kind;
      servo_id   <= 4'(res_id);
      value      <= res_value;
      low_limit  <= res_low;
      high_limit <= res_high;
      last       <= res_last;
    end
  end

  // Per-servo state memory
  shs_state_mem u_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .wr_en   (mem_we),
    .wr_addr (wr_addr),
    .wr_data (mem_wdata),
    .rd_data (ent)
  );

endmodule

[tb/servo_homing_and_slew_controller_core_test.sv]
// Testbench for the servo homing and slew controller: directed and random traffic, scored.
`timescale 1ns / 1ps

module servo_homing_and_slew_controller_core_test;
  import shs_pkg::*;

  // Mode value that the block must ignore
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  // Longest item walk is a ramp tick; leave room for two of them
  localparam int SETTLE_CYCLES = 4 * SERVOS + 8;

  typedef struct {
    logic [1:0]              kind;
    logic [3:0]              servo_id;
    logic signed [ANG_W-1:0] value;
    logic signed [ANG_W-1:0] low_limit;
    logic signed [ANG_W-1:0] high_limit;
    logic                    last;
  } servo_result_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [1:0]              mode = MODE_SET;
  logic [3:0]              servo = 4'd0;
  logic signed [ANG_W-1:0] angle = '0;
  logic                    stop_button = 1'b1;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic [1:0]              kind;
  logic [3:0]              servo_id;
  logic signed [ANG_W-1:0] value;
  logic signed [ANG_W-1:0] low_limit;
  logic signed [ANG_W-1:0] high_limit;
  logic                    last;
  logic                    wr_en = 1'b0;
  logic [1:0]              wr_index = REG_STEP_SIZE;
  logic [WDATA_W-1:0]      wr_data = '0;

  // Idling on both channels; switched off for the final stretch
  bit idling_on = 1'b1;
  int ready_hold = 0;
  int mismatch_count = 0;

  servo_result_t pending_results[$];
  servo_result_t got_expect;

  // Predicted configuration
  int cfg_step = STEP_SIZE_RST;
  int cfg_limit = SEARCH_LIMIT_RST;
  int cfg_center = CENTER_ANGLE_RST;

  // Predicted per-servo state
  int slew_pos[SERVOS];
  int slew_target[SERVOS];
  int raw_track[SERVOS];
  bit is_homed[SERVOS];
  int limit_lo[SERVOS];
  int limit_hi[SERVOS];

  // Predicted homing sequencer
  phase_t home_phase = PH_IDLE;
  int home_idx = 0;
  int search_count = 0;
  int up_count = 0;
  int down_count = 0;

  servo_homing_and_slew_controller_core DUT (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .mode       (mode),
    .servo      (servo),
    .angle      (angle),
    .stop_button(stop_button),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .kind       (kind),
    .servo_id   (servo_id),
    .value      (value),
    .low_limit  (low_limit),
    .high_limit (high_limit),
    .last       (last),
    .wr_en      (wr_en),
    .wr_index   (wr_index),
    .wr_data    (wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------- prediction

  function automatic void push_result(logic [1:0] k, int id, int v, int lo, int hi, bit lst);
    servo_result_t r;
    r.kind       = k;
    r.servo_id   = id[3:0];
    r.value      = v[ANG_W-1:0];
    r.low_limit  = lo[ANG_W-1:0];
    r.high_limit = hi[ANG_W-1:0];
    r.last       = lst;
    pending_results.push_back(r);
  endfunction

  function automatic void begin_homing_servo(int s);
    home_idx     = s;
    search_count = 0;
    up_count     = 0;
    down_count   = 0;
    if (s < SERVOS) begin
      is_homed[s] = 1'b0;
      home_phase  = PH_UP;
    end else begin
      home_phase = PH_IDLE;
    end
  endfunction

  // One raw move, clamped to the signed 12-bit range
  function automatic void raw_step(int s, int dir);
    int r;
    r = raw_track[s] + dir;
    if (r > 2047) r = 2047;
    if (r < -2048) r = -2048;
    raw_track[s] = r;
    search_count++;
    push_result(KIND_RAW, s, r, 0, 0, 1'b1);
  endfunction

  function automatic void homing_step(logic pressed_n);
    int s;
    int half;
    s = home_idx;
    if (s >= SERVOS) begin
      home_phase = PH_IDLE;
      return;
    end
    case (home_phase)
      PH_UP, PH_DOWN: begin
        if (pressed_n && search_count < cfg_limit) begin
          raw_step(s, (home_phase == PH_UP) ? 1 : -1);
        end else if (pressed_n) begin
          // search ran out with the button still released
          push_result(KIND_HOME, s, 0, 0, 0, 1'b1);
          begin_homing_servo(s + 1);
        end else begin
          if (home_phase == PH_UP) begin
            up_count   = search_count;
            home_phase = PH_BACK;
          end else begin
            down_count = search_count;
            home_phase = PH_CENTER;
          end
          search_count = 0;
        end
      end
      PH_BACK: begin
        if (search_count < up_count) begin
          raw_step(s, -1);
        end else begin
          search_count = 0;
          home_phase   = PH_DOWN;
        end
      end
      PH_CENTER: begin
        half = (up_count + down_count) / 2;
        if (search_count < half) begin
          raw_step(s, 1);
        end else begin
          slew_pos[s]    = cfg_center;
          slew_target[s] = cfg_center;
          limit_lo[s]    = cfg_center - half;
          limit_hi[s]    = cfg_center + half;
          is_homed[s]    = 1'b1;
          push_result(KIND_HOME, s, 1, limit_lo[s], limit_hi[s], 1'b1);
          begin_homing_servo(s + 1);
        end
      end
      default: home_phase = PH_IDLE;
    endcase
  endfunction

  function automatic void predict_servo_results(logic [1:0] m, logic [3:0] s,
                                                logic signed [ANG_W-1:0] a, logic b);
    int c;
    int t;
    if (m == MODE_SET) begin
      if (s < SERVOS) slew_target[s] = a;
    end else if (m == MODE_HOME) begin
      if (home_phase == PH_IDLE) begin_homing_servo(0);
    end else if (m == MODE_TICK) begin
      if (home_phase != PH_IDLE) begin
        homing_step(b);
      end else begin
        // slew every servo toward its target without overshoot
        for (int i = 0; i < SERVOS; i++) begin
          c = slew_pos[i];
          t = slew_target[i];
          if (c < t) begin
            c += cfg_step;
            if (c > t) c = t;
          end else if (c > t) begin
            c -= cfg_step;
            if (c < t) c = t;
          end
          slew_pos[i] = c;
          push_result(KIND_RAMP, i, c, 0, 0, i == SERVOS - 1);
        end
      end
    end
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(input string msg);
    if (mismatch_count < 50) $display("MISMATCH @%0t: %s", $time, msg);
    mismatch_count++;
  endtask

  // Score each output transfer, then pick the next ready level
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result kind %0d servo %0d value %0d",
                                    kind, servo_id, value));
        end else begin
          got_expect = pending_results.pop_front();
          if (kind !== got_expect.kind || servo_id !== got_expect.servo_id ||
              value !== got_expect.value || low_limit !== got_expect.low_limit ||
              high_limit !== got_expect.high_limit || last !== got_expect.last) begin
            report_mismatch($sformatf(
              "got %0d/%0d/%0d/%0d/%0d/%0d want %0d/%0d/%0d/%0d/%0d/%0d",
              kind, servo_id, value, low_limit, high_limit, last,
              got_expect.kind, got_expect.servo_id, got_expect.value,
              got_expect.low_limit, got_expect.high_limit, got_expect.last));
          end
        end
      end
      if (ready_hold > 0) begin
        ready_hold--;
        out_ready <= 1'b0;
      end else if (idling_on && $urandom_range(0, 4) == 0) begin
        ready_hold = $urandom_range(0, 5);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  // Drive one item and hold it until transferred; valid stays high afterwards
  task automatic send_item(input logic [1:0] m, input logic [3:0] s,
                           input logic signed [ANG_W-1:0] a, input logic b);
    if (idling_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    mode        <= m;
    servo       <= s;
    angle       <= a;
    stop_button <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_servo_results(m, s, a, b);
  endtask

  task automatic send_tick(input logic b);
    send_item(MODE_TICK, 4'($urandom), ANG_W'($urandom), b);
  endtask

  task automatic send_ticks(input int n, input logic b);
    repeat (n) send_tick(b);
  endtask

  task automatic send_set(input int s, input int a);
    send_item(MODE_SET, s[3:0], a[ANG_W-1:0], 1'($urandom));
  endtask

  task automatic send_home();
    send_item(MODE_HOME, 4'($urandom), ANG_W'($urandom), 1'($urandom));
  endtask

  // Items the block drops: unused mode or a servo index past the end
  task automatic send_noise();
    if ($urandom_range(0, 1) == 0)
      send_item(MODE_UNUSED, 4'($urandom), ANG_W'($urandom), 1'($urandom));
    else
      send_set($urandom_range(SERVOS, 15), $urandom_range(0, 4095));
  endtask

  function automatic logic random_button(int press_pct);
    return ($urandom_range(0, 99) < press_pct) ? 1'b0 : 1'b1;
  endfunction

  task automatic finish_homing(input int press_pct);
    while (home_phase != PH_IDLE) send_tick(random_button(press_pct));
  endtask

  // Let all results drain and the block go quiet
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_config(input int step, input int limit, input int center);
    wr_en    <= 1'b1;
    wr_index <= REG_STEP_SIZE;
    wr_data  <= step[WDATA_W-1:0];
    @(posedge clk);
    cfg_step  = step;
    wr_index <= REG_SEARCH_LIMIT;
    wr_data  <= limit[WDATA_W-1:0];
    @(posedge clk);
    cfg_limit = limit;
    wr_index <= REG_CENTER_ANGLE;
    wr_data  <= center[WDATA_W-1:0];
    @(posedge clk);
    cfg_center = center;
    wr_en <= 1'b0;
  endtask

  // ---------------------------------------------------------------- tests

  // Slew at reset settings, step 15 and step 0, plus dropped items
  task automatic test_ramp_and_ignored_items();
    send_set(0, 2047);
    send_set(1, -2048);
    send_set(2, 3);
    send_set(3, -3);
    send_set(15, 100);
    send_set(SERVOS, -1);
    send_item(MODE_UNUSED, 4'hF, -12'sd1, 1'b1);
    send_ticks(2, 1'b1);
    settle();
    write_config(15, SEARCH_LIMIT_RST, CENTER_ANGLE_RST);
    send_ticks(2, 1'b0);
    settle();
    write_config(0, SEARCH_LIMIT_RST, CENTER_ANGLE_RST);
    send_tick(1'b1);
  endtask

  // Success, failure going up, failure going down, repeated home, sets mid-run
  task automatic test_homing_paths();
    settle();
    write_config(1, 2, 180);
    send_home();
    send_home();
    send_set(0, -500);
    send_set(1, 77);
    // servo 0: one up, back, one down, center, success
    send_tick(1'b1);
    send_tick(1'b0);
    send_ticks(2, 1'b1);
    send_tick(1'b1);
    send_tick(1'b0);
    send_ticks(2, 1'b1);
    // servo 1: up search runs out
    send_ticks(3, 1'b1);
    // servo 2: down search runs out
    send_tick(1'b0);
    send_ticks(4, 1'b1);
    finish_homing(100);
    send_tick(1'b1);
  endtask

  task automatic random_traffic_phase(input int n_items);
    int counted;
    int pick;
    int s;
    int press_pct;
    counted   = 0;
    press_pct = $urandom_range(10, 40);
    while (counted < n_items) begin
      pick = $urandom_range(0, 99);
      if (home_phase != PH_IDLE) begin
        if (pick < 85) begin
          send_tick(random_button(press_pct));
          counted++;
        end else if (pick < 92) begin
          send_set($urandom_range(0, SERVOS - 1), $urandom_range(0, 4095));
          counted++;
        end else if (pick < 96) begin
          send_home();
        end else begin
          send_noise();
        end
      end else begin
        if (pick < 35) begin
          s = $urandom_range(0, SERVOS - 1);
          // half the time, a target within 40 of the current position
          if ($urandom_range(0, 1) == 0)
            send_set(s, slew_pos[s] + $urandom_range(0, 80) - 40);
          else
            send_set(s, $urandom_range(0, 4095));
          counted++;
        end else if (pick < 80) begin
          send_tick(1'($urandom));
          counted++;
        end else if (pick < 88) begin
          send_home();
          counted++;
        end else begin
          send_noise();
        end
      end
    end
    finish_homing(press_pct);
  endtask

  task automatic test_random_traffic();
    int limit;
    for (int p = 0; p < 4; p++) begin
      settle();
      limit = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 1023) : $urandom_range(1, 12);
      write_config($urandom_range(1, 15), limit, $urandom_range(0, 180));
      idling_on = (p != 3);
      random_traffic_phase(95);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_ramp_and_ignored_items();
    test_homing_paths();
    test_random_traffic();
    settle();
    if (mismatch_count == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  // Watchdog
  initial begin
    #20_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

[filelist.f]
src/shs_pkg.sv
src/shs_state_mem.sv
src/servo_homing_and_slew_controller_core.sv
tb/servo_homing_and_slew_controller_core_test.sv
